>>> sv/imhq_pkg.sv
// package for the indexed min-heap queue core
// command and status codes and heap sizes for the core; no dependencies
package imhq_pkg;
    localparam int HEAP_CAPACITY = 256;
    localparam int HANDLE_COUNT  = 256;
    localparam int RANK_BITS     = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_UP     = 2'd2,
        CMD_DOWN   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;
endpackage

>>> sv/imhq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/indexed_min_heap_queue_core.sv
// indexed min-heap queue core: one command word in, one result word out.
// a rejected command skips the heap walk; others move the entry up or down one level
// per step, and a remove also sifts the last leaf down from the root; the worst case
// is a remove on a full heap; one command at a time, the next one accepted the cycle
// after the result is registered.
// reset: heap empty; the present map is cleared by a sweep over every handle, no accept.
module indexed_min_heap_queue_core
    import imhq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // command[1:0], node_handle[9:2], node_rank[41:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[1:0], top_valid[2], top_handle[10:3],
                                   // top_rank[42:11], entry_count[51:43]
);
    localparam int SW = $clog2(HEAP_CAPACITY);
    localparam int HW = $clog2(HANDLE_COUNT);
    localparam int CW = SW + 1;
    localparam int PW = SW + 1;             // present bit + slot
    localparam int EW = 8 + RANK_BITS;      // handle + rank per slot

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_POSRD, S_POSWT, S_START, S_UPRD, S_UPCHK,
        S_DNRD0, S_DNRD1, S_DNCHK, S_PLACE, S_TOPRD, S_TOPWT, S_OUT
    } state_t;

    state_t             state_reg;
    logic [1:0]         cmd_reg;
    logic [7:0]         hnd_reg;
    logic [RANK_BITS-1:0] rank_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW:0]        pos_reg;       // current slot, wide for child math
    logic [CW:0]        child_reg;
    logic [RANK_BITS-1:0] lrank_reg;
    logic [7:0]         lhnd_reg;
    logic               moved_reg;
    logic               updown_reg;    // insert of a present handle: try down if up did not move
    logic [1:0]         stat_reg;
    logic [HW:0]        clr_reg;
    logic [55:0]        out_reg;
    logic               ovalid_reg;

    // slot memory
    logic           e_we;
    logic [SW-1:0]  e_waddr, e_raddr;
    logic [EW-1:0]  e_wdata, e_rdata;
    // position memory
    logic           p_we;
    logic [HW-1:0]  p_waddr, p_raddr;
    logic [PW-1:0]  p_wdata, p_rdata;

    imhq_ram #(.WIDTH(EW), .DEPTH(HEAP_CAPACITY)) u_slot (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    imhq_ram #(.WIDTH(PW), .DEPTH(HANDLE_COUNT)) u_pos (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));

    logic [7:0]           e_h;
    logic [RANK_BITS-1:0] e_r;
    assign e_h = e_rdata[7:0];
    assign e_r = e_rdata[EW-1:8];

    logic [CW:0] parent;
    assign parent = (pos_reg - 1'b1) >> 1;

    // remove: old root just read, the last leaf still has to sift down
    logic root_pass;
    logic out_load;
    assign root_pass = (cmd_reg == CMD_REMOVE) && (stat_reg == ST_OK) && moved_reg
                       && !updown_reg;
    assign out_load  = (state_reg == S_TOPWT) && !root_pass && (!ovalid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    // memory ports driven from state
    always_comb begin
        e_we = 1'b0; e_waddr = pos_reg[SW-1:0]; e_wdata = {rank_reg, hnd_reg};
        e_raddr = '0;
        p_we = 1'b0; p_waddr = hnd_reg[HW-1:0]; p_wdata = {1'b1, pos_reg[SW-1:0]};
        p_raddr = hnd_reg[HW-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                p_we = 1'b1; p_waddr = clr_reg[HW-1:0]; p_wdata = '0;
            end
            S_UPRD:  e_raddr = parent[SW-1:0];
            S_UPCHK: begin
                // parent moves down into current slot
                if (pos_reg != '0 && rank_reg < e_r) begin
                    e_we = 1'b1; e_wdata = e_rdata;
                    p_we = 1'b1; p_waddr = e_h[HW-1:0];
                end
            end
            S_DNRD0: e_raddr = child_reg[SW-1:0];
            S_DNRD1: e_raddr = SW'(child_reg + 1'b1);
            S_DNCHK: begin
                if (((child_reg + 1'b1) < fill_reg && lrank_reg > e_r) ? (e_r < rank_reg)
                                                                      : (lrank_reg < rank_reg)) begin
                    e_we = 1'b1;
                    if ((child_reg + 1'b1) < fill_reg && lrank_reg > e_r) begin
                        e_wdata = e_rdata; p_waddr = e_h[HW-1:0];
                    end else begin
                        e_wdata = {lrank_reg, lhnd_reg}; p_waddr = lhnd_reg[HW-1:0];
                    end
                    p_we = 1'b1;
                end
            end
            S_PLACE: begin
                e_we = 1'b1; p_we = 1'b1;
            end
            S_TOPRD: e_raddr = '0;
            S_START: e_raddr = SW'(fill_reg);   // last leaf for remove
            S_OUT: begin
                // removed root leaves the heap
                p_we = 1'b1; p_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            fill_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            if (out_load) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (HW+1)'(HANDLE_COUNT - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_tvalid && s_tready) begin
                    cmd_reg    <= s_tdata[1:0];
                    hnd_reg    <= s_tdata[9:2];
                    rank_reg   <= s_tdata[10 +: RANK_BITS];
                    stat_reg   <= ST_OK;
                    moved_reg  <= 1'b0;
                    updown_reg <= 1'b0;
                    state_reg  <= S_POSRD;
                end
                S_POSRD: state_reg <= S_POSWT;
                S_POSWT: begin
                    // p_rdata valid here; a non-empty remove reads the last leaf next
                    priority if (cmd_reg == CMD_REMOVE) begin
                        if (fill_reg == '0) begin
                            stat_reg <= ST_EMPTY; state_reg <= S_TOPRD;
                        end else begin
                            fill_reg <= fill_reg - 1'b1; state_reg <= S_START;
                        end
                    end else if (32'(hnd_reg) >= HANDLE_COUNT) begin
                        stat_reg <= ST_ABSENT; state_reg <= S_TOPRD;
                    end else if (cmd_reg == CMD_INSERT) begin
                        if (p_rdata[PW-1]) begin
                            pos_reg <= (CW+1)'(p_rdata[SW-1:0]);
                            updown_reg <= 1'b1; state_reg <= S_UPRD;
                        end else if (fill_reg >= CW'(HEAP_CAPACITY)) begin
                            stat_reg <= ST_FULL; state_reg <= S_TOPRD;
                        end else begin
                            pos_reg <= (CW+1)'(fill_reg);
                            fill_reg <= fill_reg + 1'b1; state_reg <= S_UPRD;
                        end
                    end else if (!p_rdata[PW-1]) begin
                        stat_reg <= ST_ABSENT; state_reg <= S_TOPRD;
                    end else begin
                        pos_reg <= (CW+1)'(p_rdata[SW-1:0]);
                        state_reg <= (cmd_reg == CMD_UP) ? S_UPRD : S_DNRD0;
                        child_reg <= ((CW+1)'(p_rdata[SW-1:0]) << 1) + 1'b1;
                    end
                end
                S_START: state_reg <= S_TOPRD;  // wait for the last-leaf read of a remove
                S_UPRD: begin
                    if (pos_reg == '0) begin
                        state_reg <= (updown_reg && !moved_reg) ? S_DNRD0 : S_PLACE;
                        child_reg <= (pos_reg << 1) + 1'b1;
                    end else begin
                        state_reg <= S_UPCHK;
                    end
                end
                S_UPCHK: begin
                    if (rank_reg < e_r) begin
                        pos_reg <= parent; moved_reg <= 1'b1; state_reg <= S_UPRD;
                    end else begin
                        state_reg <= (updown_reg && !moved_reg) ? S_DNRD0 : S_PLACE;
                        child_reg <= (pos_reg << 1) + 1'b1;
                    end
                end
                S_DNRD0: begin
                    if (child_reg < (CW+1)'(fill_reg)) state_reg <= S_DNRD1;
                    else state_reg <= S_PLACE;
                end
                S_DNRD1: begin
                    lrank_reg <= e_r; lhnd_reg <= e_h; state_reg <= S_DNCHK;
                end
                S_DNCHK: begin
                    if (((child_reg + 1'b1) < fill_reg && lrank_reg > e_r) ? (e_r < rank_reg)
                                                                          : (lrank_reg < rank_reg)) begin
                        if ((child_reg + 1'b1) < fill_reg && lrank_reg > e_r) begin
                            pos_reg <= child_reg + 1'b1;
                            child_reg <= ((child_reg + 1'b1) << 1) + 1'b1;
                        end else begin
                            pos_reg <= child_reg;
                            child_reg <= (child_reg << 1) + 1'b1;
                        end
                        state_reg <= S_DNRD0;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE: state_reg <= S_TOPRD;
                S_TOPRD: begin
                    if (cmd_reg == CMD_REMOVE && stat_reg == ST_OK && !moved_reg) begin
                        // first pass of remove: e_rdata holds the last leaf
                        moved_reg <= 1'b1;
                        state_reg <= S_TOPWT;
                        hnd_reg <= e_h; rank_reg <= e_r;
                    end else begin
                        state_reg <= S_TOPWT;
                    end
                end
                S_TOPWT: begin
                    if (root_pass) begin
                        // e_rdata is old root: clear its present bit, then sift leaf if the heap is not empty
                        updown_reg <= 1'b1;
                        hnd_reg <= e_h;
                        lhnd_reg <= hnd_reg; lrank_reg <= rank_reg;
                        state_reg <= S_OUT;
                    end else if (out_load) begin
                        out_reg <= {4'd0, fill_reg,
                                    (fill_reg != '0) ? 32'(e_r) : 32'd0,
                                    (fill_reg != '0) ? e_h : 8'd0,
                                    (fill_reg != '0), stat_reg};
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT: begin
                    // present bit of old root cleared this cycle
                    hnd_reg <= lhnd_reg; rank_reg <= lrank_reg;
                    pos_reg <= '0; child_reg <= (CW+1)'(1);
                    cmd_reg <= CMD_DOWN;
                    state_reg <= (fill_reg == '0) ? S_TOPRD : S_DNRD0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
